/* hw/rtl/multitap_feedback_delay_reverb_unit_assert.svh */
// assertion macros for the multitap feedback delay reverb unit
// used by the port checker; needs clk and rst in the including scope
`ifndef MULTITAP_FEEDBACK_DELAY_REVERB_UNIT_ASSERT_SVH
`define MULTITAP_FEEDBACK_DELAY_REVERB_UNIT_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define MFDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define MFDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mfdr_pkg.sv */
// shared constants, types and helper functions of the reverb unit
// no dependencies; imported by the top level and the port checker
`timescale 1ns / 1ps

package mfdr_pkg;

  localparam int DELAY_DEPTH = 32768;
  localparam int TAP_COUNT   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 16;
  localparam longint unsigned TAP_MAGIC = 64'd19783;

  localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
  localparam int TAP_IDX_BITS = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 8;

  // product of a sample and a 17-bit unsigned coefficient
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 2;
  // input shifted up plus TAP_COUNT products, with headroom
  localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + 1 + $clog2(TAP_COUNT + 1) + 1;
  localparam int LP_BITS   = PROD_BITS + 2;

  localparam logic [ADDR_BITS:0]   DEPTH_W   = (ADDR_BITS + 1)'(DELAY_DEPTH);
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DELAY_DEPTH - 1);
  localparam logic [TAP_IDX_BITS-1:0] LAST_TAP = TAP_IDX_BITS'(TAP_COUNT - 1);

  localparam logic [COEF_BITS-1:0] GAIN_RESET = COEF_BITS'(3932);
  localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(6554);
  localparam logic [COEF_BITS:0]   COEF_ONE   = (COEF_BITS + 1)'(1 << COEF_BITS);

  localparam logic signed [ACC_BITS-1:0] ACC_SAT_MAX = ACC_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] ACC_SAT_MIN = ACC_BITS'(-(1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_BITS-1:0] ACC_HALF    = ACC_BITS'(1 << (FRAC_BITS - 1));
  localparam logic signed [LP_BITS-1:0]  LP_HALF     = LP_BITS'(1 << (FRAC_BITS - 1));

  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = ACC_SAT_MAX[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = ACC_SAT_MIN[SAMPLE_BITS-1:0];

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWPASS_COEF  = CFG_INDEX_BITS'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_ROUND,
    ST_LP_OLD,
    ST_LP_NEW,
    ST_LP_WRITE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          hit;
  } sat_t;

  typedef logic [ADDR_BITS-1:0] tap_table_t [TAP_COUNT];

  // tap offsets from t = (t * magic + magic) mod depth, evaluated at elaboration
  function automatic tap_table_t build_tap_table();
    tap_table_t      tab;
    longint unsigned t;
    t = 0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      t = (t * TAP_MAGIC + TAP_MAGIC) % DELAY_DEPTH;
      tab[k] = t[ADDR_BITS-1:0];
    end
    return tab;
  endfunction

  localparam tap_table_t TAP_OFFSET = build_tap_table();

  function automatic sat_t saturate(input logic signed [ACC_BITS-1:0] v);
    sat_t r;
    if (v > ACC_SAT_MAX) begin
      r.value = SAT_MAX;
      r.hit   = 1'b1;
    end else if (v < ACC_SAT_MIN) begin
      r.value = SAT_MIN;
      r.hit   = 1'b1;
    end else begin
      r.value = v[SAMPLE_BITS-1:0];
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mfdr_delay_ram.sv */
// single-port synchronous ram for the delay line, read-first, registered read data
// generic; no package dependency
`timescale 1ns / 1ps

module mfdr_delay_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/multitap_feedback_delay_reverb_unit.sv */
// sequence: after s_tdata is accepted, m_tvalid rises once the 16 tap reads, the pipeline
//   drain and the rounding step are done, later if the output is stalled
// pacing: one word at a time, set by the single port of the delay ram
//   (16 tap reads plus one write-back) and the shared multiplier of the lowpass
// reset: synchronous; then a clearing pass zeroes all 32768 ram entries, one per cycle,
//   with s_tready low and config writes taken; depends on mfdr_pkg and mfdr_delay_ram
`timescale 1ns / 1ps

module multitap_feedback_delay_reverb_unit
  import mfdr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [TDATA_BITS-1:0]     s_tdata,   // [15:0] sample_in
  // output stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [TDATA_BITS-1:0]     m_tdata,   // [15:0] sample_out
  output logic                      m_tuser,   // [0] clipped
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]      cfg_data
);

  state_t state, state_next;

  // config registers
  logic [COEF_BITS-1:0] feedback_gain;
  logic [COEF_BITS-1:0] lowpass_coef;

  // per-item state
  logic [ADDR_BITS-1:0]          wp;
  logic signed [SAMPLE_BITS-1:0] lowpass_state;
  logic [ADDR_BITS-1:0]          clr_addr;
  logic [TAP_IDX_BITS-1:0]       tap_cnt;

  // tap pipeline: ram read -> product -> accumulate
  logic                          rd_valid, rd_neg;
  logic                          prod_valid, prod_neg;
  logic signed [PROD_BITS-1:0]   prod, prod_next;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [PROD_BITS-1:0]   lp_part;

  // result register
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_clip;

  // ram port
  logic [ADDR_BITS-1:0]   ram_addr;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // shared multiplier operands
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic [COEF_BITS:0]            mul_b;

  logic                          round_fire;
  logic [ADDR_BITS:0]            tap_sum;
  logic [ADDR_BITS-1:0]          tap_addr;
  logic signed [ACC_BITS-1:0]    acc_round;
  sat_t                          y_sat;
  logic signed [LP_BITS-1:0]     lp_sum;
  logic signed [LP_BITS-1:0]     lp_shift;
  sat_t                          lp_sat;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  assign in_sample = s_tdata[SAMPLE_BITS-1:0];
  assign cfg_ready = 1'b1;
  assign m_tdata   = TDATA_BITS'($unsigned(out_sample));
  assign m_tuser   = out_clip;

  mfdr_delay_ram #(
    .DEPTH(DELAY_DEPTH),
    .WIDTH(SAMPLE_BITS)
  ) u_ram (
    .clk  (clk),
    .addr (ram_addr),
    .we   (ram_we),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // tap address: write pointer plus fixed offset, wrapped once
  always_comb begin
    tap_sum = {1'b0, wp} + {1'b0, TAP_OFFSET[tap_cnt]};
    if (tap_sum >= DEPTH_W) begin
      tap_sum = tap_sum - DEPTH_W;
    end
    tap_addr = tap_sum[ADDR_BITS-1:0];
  end

  // round half up, then clip to the sample range
  assign acc_round = (acc + ACC_HALF) >>> FRAC_BITS;
  assign y_sat     = saturate(acc_round);

  // lowpass: old-state product was parked in lp_part, new-sample product sits in prod
  assign lp_sum   = LP_BITS'(lp_part) + LP_BITS'(prod) + LP_HALF;
  assign lp_shift = lp_sum >>> FRAC_BITS;
  assign lp_sat   = saturate(ACC_BITS'(lp_shift));

  assign prod_next = mul_a * $signed({1'b0, mul_b});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_TAPS;
      end
      ST_TAPS: begin
        if (tap_cnt == LAST_TAP) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_valid && !prod_valid) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        // hold here while the previous result is still waiting
        if (!m_tvalid || m_tready) state_next = ST_LP_OLD;
      end
      ST_LP_OLD:   state_next = ST_LP_NEW;
      ST_LP_NEW:   state_next = ST_LP_WRITE;
      ST_LP_WRITE: state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    round_fire = 1'b0;
    ram_addr   = tap_addr;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    mul_a      = $signed(ram_rdata);
    mul_b      = {1'b0, feedback_gain};
    unique case (state)
      ST_CLEAR: begin
        ram_addr = clr_addr;
        ram_we   = 1'b1;
      end
      ST_IDLE:  s_tready = 1'b1;
      ST_TAPS:  ;
      ST_DRAIN: ;
      ST_ROUND: round_fire = !m_tvalid || m_tready;
      ST_LP_OLD: begin
        mul_a = lowpass_state;
        mul_b = COEF_ONE - {1'b0, lowpass_coef};
      end
      ST_LP_NEW: begin
        mul_a = out_sample;
        mul_b = {1'b0, lowpass_coef};
      end
      ST_LP_WRITE: begin
        ram_addr  = wp;
        ram_we    = 1'b1;
        ram_wdata = lp_sat.value;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      tap_cnt       <= '0;
      wp            <= '0;
      lowpass_state <= '0;
      feedback_gain <= GAIN_RESET;
      lowpass_coef  <= COEF_RESET;
      rd_valid      <= 1'b0;
      prod_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= (state == ST_TAPS);
      prod_valid <= rd_valid;

      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;

      if (state == ST_TAPS) begin
        tap_cnt <= (tap_cnt == LAST_TAP) ? '0 : tap_cnt + 1'b1;
      end

      if (round_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (state == ST_LP_WRITE) begin
        lowpass_state <= lp_sat.value;
        wp            <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
          REG_LOWPASS_COEF:  lowpass_coef  <= cfg_data;
          default: ;  // unknown index, write dropped
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // odd taps subtract
    rd_neg   <= tap_cnt[0];
    prod_neg <= rd_neg;
    prod     <= prod_next;

    if (s_tvalid && s_tready) begin
      acc <= ACC_BITS'(in_sample) <<< FRAC_BITS;
    end else if (prod_valid) begin
      acc <= prod_neg ? acc - ACC_BITS'(prod) : acc + ACC_BITS'(prod);
    end

    if (state == ST_LP_NEW) lp_part <= prod;

    if (round_fire) begin
      out_sample <= y_sat.value;
      out_clip   <= y_sat.hit;
    end
  end

endmodule

/* hw/rtl/mfdr_checker.sv */
// port-level checker for the reverb unit, bound to the top level
// depends on mfdr_pkg and multitap_feedback_delay_reverb_unit_assert.svh
`timescale 1ns / 1ps
`include "multitap_feedback_delay_reverb_unit_assert.svh"

module mfdr_checker
  import mfdr_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [TDATA_BITS-1:0]     m_tdata,
  input logic                      m_tuser
);

  logic signed [SAMPLE_BITS-1:0] out_sample;
  assign out_sample = m_tdata[SAMPLE_BITS-1:0];

  // a stalled result word holds
  `MFDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // one word at a time: no accept right after an accept
  `MFDR_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while previous word in flight")

  // a clipped result sits on a rail
  `MFDR_ASSERT_NOW(a_clip_rail, m_tvalid && m_tuser, out_sample == SAT_MAX || out_sample == SAT_MIN, "clipped flag without saturated sample")

  // a new result appears only while the lowpass write-back is pending
  `MFDR_ASSERT_NOW(a_result_busy, $rose(m_tvalid), !s_tready, "result appeared while idle")

endmodule

bind multitap_feedback_delay_reverb_unit mfdr_checker u_checker (.*);
